@@ src/asfc_pkg.sv @@
package asfc_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MODE_W   = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PCM16_TO_F32 = 2'd0,
    MODE_PCM32_TO_F32 = 2'd1,
    MODE_F32_TO_PCM16 = 2'd2,
    MODE_UNUSED       = 2'd3
  } mode_t;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONFINITE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

@@ src/asfc_conv.sv @@
module asfc_conv (
  input  asfc_pkg::mode_t         mode,
  input  logic [31:0]             sample_word,
  output asfc_pkg::result_t       result
);

  // integer to float path (pcm16 enters pre-shifted into the top half)
  logic [31:0] ival;
  logic        ineg;
  logic [31:0] imag;
  logic [4:0]  lz;
  logic [31:0] norm;
  logic        rnd_up;
  logic [30:0] fbody;
  logic [31:0] fword;

  // float to pcm16 path
  logic [7:0]  ef;
  logic [23:0] mant;
  logic [7:0]  ee;
  logic [7:0]  sh;
  logic [15:0] scale;
  logic [39:0] prod;
  logic [39:0] shifted;
  logic [16:0] rmag;
  logic [15:0] pcm;
  logic        fneg;

  always_comb begin
    ival = (mode == asfc_pkg::MODE_PCM16_TO_F32) ? {sample_word[15:0], 16'h0000}
                                                 : sample_word;
    ineg = ival[31];
    imag = ineg ? (~ival + 32'd1) : ival;
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (imag[i]) lz = 5'(31 - i);
    end
    norm   = imag << lz;
    rnd_up = norm[7] & ((|norm[6:0]) | norm[8]);
    fbody  = {8'(8'd127 - {3'b000, lz}), norm[30:8]} + {30'd0, rnd_up};
    fword  = (imag == 32'd0) ? 32'd0 : {ineg, fbody};
  end

  always_comb begin
    ef    = sample_word[30:23];
    fneg  = sample_word[31];
    mant  = {(ef != 8'd0), sample_word[22:0]};
    ee    = (ef == 8'd0) ? 8'd1 : ef;
    sh    = 8'd149 - ee;           // one less than the full shift, for rounding
    scale = fneg ? 16'd32768 : 16'd32767;
    prod  = {16'd0, mant} * {24'd0, scale};
    shifted = (sh >= 8'd40) ? 40'd0 : (prod >> sh);
    rmag  = 17'((shifted + 40'd1) >> 1);  // half away from zero on magnitude
    pcm   = fneg ? 16'(~rmag + 17'd1) : rmag[15:0];
  end

  always_comb begin
    result.word   = '0;
    result.status = asfc_pkg::STATUS_OK;
    unique case (mode)
      asfc_pkg::MODE_PCM16_TO_F32,
      asfc_pkg::MODE_PCM32_TO_F32: result.word = fword;
      asfc_pkg::MODE_F32_TO_PCM16: begin
        if (ef == 8'hFF) begin
          result.status = asfc_pkg::STATUS_NONFINITE;
        end else if (sample_word[30:0] > 31'h3F800000) begin
          result.status = asfc_pkg::STATUS_RANGE;
        end else begin
          result.word = {16'h0000, pcm};
        end
      end
      default: result.word = '0;
    endcase
  end

endmodule

@@ src/audio_sample_format_converter_core.sv @@
// Audio sample format converter. Each transfer on the input stream carries one
// sample word and yields exactly one result transfer, registered and shown in the
// next cycle, taken only when the output is free: a sustained rate of one sample
// per clock while out_tready holds, set by the single result register. cfg_wdata
// selects the mode (0 pcm16 to float32, 1 pcm32 to float32, 2 float32 to pcm16;
// mode 3 returns zero). Write it only when idle. out_tuser carries the status:
// 0 ok, 1 non-finite input, 2 out of range; the word is zero whenever the status is not ok.
module audio_sample_format_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_wdata,     // conversion_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [31:0] sample_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [31:0] out_word
  output logic [1:0]  out_tuser      // [1:0] status
);

  asfc_pkg::mode_t   mode_r;
  asfc_pkg::result_t res_nxt;
  asfc_pkg::result_t res_r;
  logic              out_valid_r;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= asfc_pkg::MODE_PCM16_TO_F32;
    end else if (cfg_wen) begin
      mode_r <= asfc_pkg::mode_t'(cfg_wdata);
    end
  end

  // Conversion is shallow, so it sits directly ahead of the result register
  asfc_conv u_conv (
    .mode        (mode_r),
    .sample_word (in_tdata),
    .result      (res_nxt)
  );

  // Accept whenever the result register is empty or being drained
  assign in_tready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r.word;
  assign out_tuser  = res_r.status;

  // A stalled result must not be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  // Any accepted transfer appears on the output next cycle
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted transfer lost");

  // Error results carry a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != asfc_pkg::STATUS_OK) |-> out_tdata == 32'd0)
    else $error("error result with non-zero word");

endmodule

@@ bench/audio_sample_format_converter_core_checker.sv @@
module audio_sample_format_converter_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  asfc_pkg::mode_t   cur_mode;
  asfc_pkg::result_t awaited_q[$];

  function automatic int msb_index(logic [63:0] v);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++)
      if (v[i]) p = i;
    return p;
  endfunction

  // signed value / 2^scale as float32, nearest-even where bits are lost
  function automatic logic [31:0] fixed_to_float(logic sgn, logic [63:0] mag, int scale);
    int          p;
    int          sh;
    logic [7:0]  expo;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    if (mag == 64'd0) return 32'h0;
    p    = msb_index(mag);
    expo = 8'(p - scale + 127);
    if (p <= 23) begin
      keep = mag << (23 - p);
    end else begin
      sh   = p - 23;
      keep = mag >> sh;
      rem  = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
      if (keep == (64'd1 << 24)) begin
        keep = keep >> 1;
        expo = expo + 8'd1;
      end
    end
    return {sgn, expo, keep[22:0]};
  endfunction

  // float32 to pcm16, half away from zero, asymmetric scaling
  function automatic asfc_pkg::result_t float_to_q15(logic [31:0] w);
    asfc_pkg::result_t r;
    logic [7:0]        expo;
    logic [63:0]       man;
    logic [63:0]       prod;
    logic [63:0]       mag;
    int                sh;
    logic [15:0]       q;
    expo = w[30:23];
    r.word   = 32'h0;
    r.status = asfc_pkg::STATUS_OK;
    if (expo == 8'hFF) begin
      r.status = asfc_pkg::STATUS_NONFINITE;
      return r;
    end
    if (w[30:0] > 31'h3F800000) begin
      r.status = asfc_pkg::STATUS_RANGE;
      return r;
    end
    man  = (expo == 0) ? {41'd0, w[22:0]} : {40'd0, 1'b1, w[22:0]};
    prod = man * (w[31] ? 64'd32768 : 64'd32767);
    sh   = 150 - ((expo == 0) ? 1 : int'(expo));
    mag  = (sh > 60) ? 64'd0 : ((prod + (64'd1 << (sh - 1))) >> sh);
    q    = w[31] ? 16'(-mag) : 16'(mag);
    r.word = {16'h0, q};
    return r;
  endfunction

  function automatic asfc_pkg::result_t convert_sample(asfc_pkg::mode_t m, logic [31:0] w);
    asfc_pkg::result_t r;
    r.word   = 32'h0;
    r.status = asfc_pkg::STATUS_OK;
    case (m)
      asfc_pkg::MODE_PCM16_TO_F32: begin
        r.word = fixed_to_float(w[15],
                                w[15] ? 64'h10000 - w[15:0] : {48'd0, w[15:0]}, 15);
      end
      asfc_pkg::MODE_PCM32_TO_F32: begin
        r.word = fixed_to_float(w[31], w[31] ? 64'h100000000 - w : {32'd0, w}, 31);
      end
      asfc_pkg::MODE_F32_TO_PCM16: r = float_to_q15(w);
      default: ;
    endcase
    return r;
  endfunction

  assign pending = awaited_q.size();

  always @(posedge clk) begin
    asfc_pkg::result_t e;
    if (!rst_n) begin
      cur_mode <= asfc_pkg::MODE_PCM16_TO_F32;
      awaited_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wen) cur_mode <= asfc_pkg::mode_t'(cfg_wdata);
      if (in_tvalid && in_tready) awaited_q = {awaited_q, convert_sample(cur_mode, in_tdata)};
      if (out_tvalid && out_tready) begin
        if (awaited_q.size() == 0) begin
          $display("%t: unexpected result word=%h status=%0d", $time, out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          e = awaited_q.pop_front();
          if (e.word !== out_tdata || e.status !== out_tuser) begin
            $display("%t: mismatch expected word=%h status=%0d actual word=%h status=%0d",
                     $time, e.word, e.status, out_tdata, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ bench/audio_sample_format_converter_core_tb.sv @@
module audio_sample_format_converter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_wen;
  logic [1:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // [31:0] sample_word
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [31:0] out_word
  logic [1:0]  out_tuser;   // [1:0] status
  int          pending;
  int          fail_count;
  int          idle_in;     // percent of cycles the sender holds off
  int          idle_out;    // percent of cycles the receiver stalls

  audio_sample_format_converter_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  audio_sample_format_converter_core_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_out);
  end

  // one sample transfer; random hold-off before it
  task automatic push_sample(logic [31:0] w);
    while ($urandom_range(99) < idle_in) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  // mode change only once the pipe has drained
  task automatic set_mode(asfc_pkg::mode_t m);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  function automatic logic [31:0] random_sample(asfc_pkg::mode_t m);
    int pick;
    pick = $urandom_range(99);
    if (m == asfc_pkg::MODE_F32_TO_PCM16) begin
      // mostly in-range floats, some specials and raw noise
      if (pick < 65) return {1'($urandom), 8'($urandom_range(126, 95)), 23'($urandom)};
      if (pick < 70) return {1'($urandom), 8'($urandom_range(94)), 23'($urandom)};
      if (pick < 75) return {1'($urandom), 31'h3F800000};
      if (pick < 85) return {1'($urandom), 8'hFF, 23'($urandom_range(1) ? $urandom : 0)};
      return $urandom;
    end
    if (m == asfc_pkg::MODE_PCM32_TO_F32 && pick < 20) return $urandom >> $urandom_range(31);
    return $urandom;
  endfunction

  initial begin
    asfc_pkg::mode_t modes[4];
    int              counts[4];
    logic [31:0]     dir16[6];
    logic [31:0]     dir32[6];
    logic [31:0]     dirf[9];

    modes  = '{asfc_pkg::MODE_PCM16_TO_F32, asfc_pkg::MODE_PCM32_TO_F32,
               asfc_pkg::MODE_F32_TO_PCM16, asfc_pkg::MODE_UNUSED};
    counts = '{180, 180, 240, 50};
    dir16  = '{32'h0, 32'h1, 32'h7FFF, 32'h8000, 32'hFFFF, 32'hFFFF8000};
    dir32  = '{32'h0, 32'h1, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h01000003};
    // 1.0, -1.0, -0.0, inf, NaN, just above one, denormal, +/-0.5 (+0.5 is a tie)
    dirf   = '{32'h3F800000, 32'hBF800000, 32'h80000000, 32'h7F800000, 32'hFFC00000,
               32'h3F800001, 32'h00000001, 32'h3F000000, 32'hBF000000};

    rst_n      = 1'b0;
    cfg_wen    = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    idle_in    = 0;
    idle_out   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset mode is pcm16
    foreach (dir16[i]) push_sample(dir16[i]);
    set_mode(asfc_pkg::MODE_PCM32_TO_F32);
    foreach (dir32[i]) push_sample(dir32[i]);
    set_mode(asfc_pkg::MODE_F32_TO_PCM16);
    foreach (dirf[i]) push_sample(dirf[i]);
    set_mode(asfc_pkg::MODE_UNUSED);
    push_sample(32'hDEADBEEF);

    // random: three idling profiles, every mode in each
    for (int prof = 0; prof < 3; prof++) begin
      idle_in  = (prof == 0) ? 25 : (prof == 1) ? 57 : 0;
      idle_out = (prof == 0) ? 57 : (prof == 1) ? 25 : 0;
      foreach (modes[k]) begin
        set_mode(modes[k]);
        repeat (counts[k]) push_sample(random_sample(modes[k]));
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("audio_sample_format_converter_core_tb: PASS");
    end else begin
      $display("audio_sample_format_converter_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("audio_sample_format_converter_core_tb: FAIL");
    $finish;
  end

endmodule
